// File: rtl/core/lprr_pkg.sv
// Shared types and codes for the length-prefixed record ring.
package lprr_pkg;

    localparam logic [1:0] REQ_PUB_START = 2'd0;
    localparam logic [1:0] REQ_PUB_BYTE  = 2'd1;
    localparam logic [1:0] REQ_RD_HDR    = 2'd2;
    localparam logic [1:0] REQ_RD_BYTE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DENIED    = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_TOO_LARGE = 3'd4;
    localparam logic [2:0] ST_CORRUPT   = 3'd5;
    localparam logic [2:0] ST_LOST      = 3'd6;

    localparam int JOB_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] event_uid;
        logic        is_system;
        logic [15:0] record_length;
        logic [7:0]  data_byte;
        logic [15:0] room;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic [15:0] out_length;
        logic [63:0] lost_count;
        logic        wake;
        logic        ready_res;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  req;
        logic        allowed;
        logic        bad_len;
        logic [15:0] len;
        logic [7:0]  data;
        logic [15:0] room;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: rtl/core/lprr_ram.sv
// Generic single-port RAM with registered read data.
module lprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/lprr_front.sv
// Input side: owner register, event filter and length check, push into the job queue.
module lprr_front #(
    parameter int MAX_EVENT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lprr_pkg::t_in_item i_in_data,
    input  lprr_pkg::t_q_stat  i_qstat,
    output logic               o_push,
    output lprr_pkg::t_job     o_job
);
    import lprr_pkg::*;

    logic [31:0] r_owner_uid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_uid <= '0;
        end else if (i_cfg_we) begin
            r_owner_uid <= i_cfg_wdata;
        end
    end

    assign o_in_stall = i_qstat.full;
    assign o_push     = i_in_valid && !i_qstat.full;

    always_comb begin
        o_job.req     = i_in_data.req_type;
        o_job.allowed = (r_owner_uid == 32'd0) ||
                        (!i_in_data.is_system && (r_owner_uid == i_in_data.event_uid));
        o_job.bad_len = (i_in_data.record_length == 16'd0) ||
                        (i_in_data.record_length > 16'(MAX_EVENT));
        o_job.len     = i_in_data.record_length;
        o_job.data    = i_in_data.data_byte;
        o_job.room    = i_in_data.room;
    end

endmodule

// File: rtl/core/lprr_queue.sv
// Short job queue between the classifying front and the executing back.
module lprr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lprr_pkg::t_job    i_job,
    input  logic              i_pop,
    output lprr_pkg::t_job    o_job,
    output lprr_pkg::t_q_stat o_stat
);
    import lprr_pkg::*;

    localparam int AW = $clog2(JOB_DEPTH);

    t_job          r_mem [JOB_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [AW:0]   n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(JOB_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(JOB_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (AW + 1)'(JOB_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// File: rtl/core/lprr_back.sv
// Execution side: ring pointers, counters, ring memory access and the result register.
module lprr_back #(
    parameter int QUEUE_BYTES = 1024,
    parameter int MAX_EVENT   = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lprr_pkg::t_job      i_job,
    input  lprr_pkg::t_q_stat   i_qstat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lprr_pkg::t_out_item o_out_data
);
    import lprr_pkg::*;

    localparam int PW = $clog2(QUEUE_BYTES);
    localparam int UW = $clog2(QUEUE_BYTES + 1);
    localparam int EW = $clog2(MAX_EVENT + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HDR  = 5'b00010,
        S_RH0  = 5'b00100,
        S_RH1  = 5'b01000,
        S_RB   = 5'b10000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [PW-1:0] r_head;
    logic [PW-1:0] n_head;
    logic [PW-1:0] r_tail;
    logic [PW-1:0] n_tail;
    logic [UW-1:0] r_used;
    logic [UW-1:0] n_used;
    logic [63:0]   r_lost;
    logic [63:0]   n_lost;
    logic [EW-1:0] r_wp;
    logic [EW-1:0] n_wp;
    logic [EW-1:0] r_rp;
    logic [EW-1:0] n_rp;
    logic [7:0]    r_lo;
    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          out_free;
    logic          done;
    logic          reported;
    t_out_item     res;
    logic          ram_we;
    logic [PW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [63:0]   lost_inc;
    logic          used_nz;
    logic          lost_nz;
    logic          space_short;
    logic [15:0]   hl;
    logic [UW:0]   free_bytes;

    function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [1:0] n);
        logic [PW:0] s;
        s = {1'b0, p} + (PW + 1)'(n);
        if (s >= (PW + 1)'(QUEUE_BYTES)) begin
            s = s - (PW + 1)'(QUEUE_BYTES);
        end
        return s[PW-1:0];
    endfunction

    lprr_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_BYTES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || !i_out_stall;
    assign used_nz     = (r_used != '0);
    assign lost_nz     = (r_lost != 64'd0);
    assign lost_inc    = (&r_lost) ? r_lost : r_lost + 64'd1;
    assign free_bytes  = (UW + 1)'(QUEUE_BYTES) - {1'b0, r_used};
    assign space_short = ({2'b00, i_job.len} + 18'd2) > 18'(free_bytes);
    assign hl          = {ram_rdata, r_lo};

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_used    = r_used;
        n_lost    = r_lost;
        n_wp      = r_wp;
        n_rp      = r_rp;
        done      = 1'b0;
        reported  = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_head;
        ram_wdata = i_job.data;
        res       = '0;
        res.status = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (!i_qstat.empty) begin
                    case (i_job.req)
                        REQ_PUB_START: begin
                            if (!i_job.allowed || (r_wp != '0)) begin
                                res.status = ST_DENIED;
                                done = out_free;
                            end else if (i_job.bad_len || lost_nz || space_short) begin
                                res.status = ST_DROPPED;
                                res.wake   = !(used_nz || lost_nz);
                                done = out_free;
                                if (out_free) begin
                                    n_lost = lost_inc;
                                end
                            end else begin
                                ram_we    = 1'b1;
                                ram_addr  = r_tail;
                                ram_wdata = i_job.len[7:0];
                                n_state   = S_HDR;
                            end
                        end
                        REQ_PUB_BYTE: begin
                            if (r_wp == '0) begin
                                res.status = ST_DENIED;
                                done = out_free;
                            end else if (out_free) begin
                                ram_we    = 1'b1;
                                ram_addr  = r_tail;
                                ram_wdata = i_job.data;
                                n_tail    = ptr_add(r_tail, 2'd1);
                                n_used    = r_used + 1'b1;
                                n_wp      = r_wp - 1'b1;
                                done      = 1'b1;
                            end
                        end
                        REQ_RD_HDR: begin
                            if (r_wp != '0) begin
                                res.status = ST_EMPTY;
                                done = out_free;
                            end else if (r_rp != '0) begin
                                res.status = ST_DENIED;
                                done = out_free;
                            end else if (r_used >= UW'(2)) begin
                                ram_addr = r_head;
                                n_state  = S_RH0;
                            end else if (!used_nz && lost_nz) begin
                                res.status = ST_LOST;
                                reported   = 1'b1;
                                done = out_free;
                                if (out_free) begin
                                    n_lost = 64'd0;
                                end
                            end else begin
                                res.status = ST_EMPTY;
                                done = out_free;
                            end
                        end
                        REQ_RD_BYTE: begin
                            if ((r_rp == '0) || !used_nz) begin
                                res.status = ST_DENIED;
                                done = out_free;
                            end else begin
                                ram_addr = r_head;
                                n_state  = S_RB;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_HDR: begin
                ram_we    = 1'b1;
                ram_addr  = ptr_add(r_tail, 2'd1);
                ram_wdata = i_job.len[15:8];
                res.wake  = !used_nz;
                if (out_free) begin
                    n_tail  = ptr_add(r_tail, 2'd2);
                    n_used  = r_used + UW'(2);
                    n_wp    = i_job.len[EW-1:0];
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RH0: begin
                ram_addr = ptr_add(r_head, 2'd1);
                n_state  = S_RH1;
            end
            S_RH1: begin
                ram_addr = ptr_add(r_head, 2'd1);
                if ((hl > 16'(MAX_EVENT)) || (({2'b00, hl} + 18'd2) > 18'(r_used))) begin
                    res.status = ST_CORRUPT;
                    if (out_free) begin
                        n_head = '0;
                        n_tail = '0;
                        n_used = '0;
                        n_lost = lost_inc;
                    end
                end else if (hl > i_job.room) begin
                    res.status     = ST_TOO_LARGE;
                    res.out_length = hl;
                end else begin
                    res.out_length = hl;
                    if (out_free) begin
                        n_head = ptr_add(r_head, 2'd2);
                        n_used = r_used - UW'(2);
                        n_rp   = hl[EW-1:0];
                    end
                end
                if (out_free) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RB: begin
                ram_addr     = r_head;
                res.out_byte = ram_rdata;
                if (out_free) begin
                    n_head  = ptr_add(r_head, 2'd1);
                    n_used  = r_used - 1'b1;
                    n_rp    = r_rp - 1'b1;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.lost_count = reported ? r_lost : n_lost;
        res.ready_res  = (n_used != '0) || (n_lost != 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_used      <= '0;
            r_lost      <= '0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_used  <= n_used;
            r_lost  <= n_lost;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RH0) begin
            r_lo <= ram_rdata;
        end
        if (done) begin
            r_out_data <= res;
        end
    end

    assign o_pop       = done;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/core/length_prefixed_record_ring.sv
// Top level of the length-prefixed record ring: front, job queue and back.
//
// Requests enter on the input channel (i_in_valid / o_in_stall / i_in_data) and
// every request gives exactly one result beat on the output channel
// (o_out_valid / i_out_stall / o_out_data), in request order.
// The owner uid register is written through i_cfg_we / i_cfg_wdata; the user must
// write it only while idle, the block itself does not enforce it. A two-entry job
// queue separates the front from the back, so requests are taken while the back is
// busy or a result waits in the output register. The back uses one ring memory
// port, one access per cycle: a publish body byte is one write, a publish start
// two header writes, a read body byte one read and a read header two reads behind
// the registered read data. Refused, dropped and reporting requests are answered
// from the idle state. While the receiver stalls, the result holds in the output
// register and the back waits on its final step; once the queue fills, o_in_stall
// rises. Synchronous reset empties the ring, clears the lost count, pointers and
// pending counts, sets the owner uid to zero and drops queued requests.
module length_prefixed_record_ring #(
    parameter int QUEUE_BYTES = 1024,
    parameter int MAX_EVENT   = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lprr_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lprr_pkg::t_out_item o_out_data
);
    import lprr_pkg::*;

    logic    push;
    logic    pop;
    t_job    front_job;
    t_job    head_job;
    t_q_stat qstat;

    lprr_front #(
        .MAX_EVENT (MAX_EVENT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_job       (front_job)
    );

    lprr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (qstat)
    );

    lprr_back #(
        .QUEUE_BYTES (QUEUE_BYTES),
        .MAX_EVENT   (MAX_EVENT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sim/length_prefixed_record_ring_tb.sv
// Self-checking testbench for the length-prefixed record ring with a built-in ring predictor.
`timescale 1ns / 100ps

module length_prefixed_record_ring_tb;
    import lprr_pkg::*;

    localparam int RING_BYTES     = 1024;
    localparam int EVENT_MAX      = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AFTER     = 300;
    localparam int DRAIN_CYCLES   = 20;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    length_prefixed_record_ring #(
        .QUEUE_BYTES(RING_BYTES),
        .MAX_EVENT  (EVENT_MAX)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Predicted ring state.
    logic [7:0]  ring_copy [0:RING_BYTES-1];
    logic [9:0]  pred_rd        = '0;
    logic [9:0]  pred_wr        = '0;
    logic [10:0] pred_fill      = '0;
    logic [63:0] pred_lost      = '0;
    logic [15:0] pred_body_left = '0;
    logic [15:0] pred_open_left = '0;
    logic [31:0] pred_owner     = '0;

    t_in_item  pending_requests [$];
    t_out_item expected_replies [$];

    int served_count = 0;
    int mismatches   = 0;
    int in_beats     = 0;
    int out_beats    = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_left    = 0;
    int idle_cycles  = 0;
    bit hold_done    = 1'b0;
    bit sender_quiet   = 1'b0;
    bit receiver_quiet = 1'b0;

    function automatic int gap_len(bit quiet);
        int k;
        k = $urandom_range(0, 99);
        if (quiet || k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_ring_byte(logic [7:0] v);
        ring_copy[pred_wr] = v;
        pred_wr = pred_wr + 10'd1;
        pred_fill = pred_fill + 11'd1;
    endtask

    task automatic pop_ring_bytes(logic [9:0] n);
        pred_rd = pred_rd + n;
        pred_fill = pred_fill - 11'(n);
    endtask

    task automatic bump_lost();
        if (pred_lost != '1) pred_lost = pred_lost + 64'd1;
    endtask

    task automatic apply_ring_request(t_in_item it);
        t_out_item   exp;
        logic        allowed;
        logic        had_backlog;
        logic        reported;
        logic [15:0] hl;
        logic [63:0] lost_snap;
        exp = '0;
        exp.status = ST_OK;
        reported = 1'b0;
        lost_snap = '0;
        case (it.req_type)
            REQ_PUB_START: begin
                allowed = (pred_owner == 0) ||
                          (!it.is_system && pred_owner == it.event_uid);
                if (!allowed || pred_body_left != 0) begin
                    exp.status = ST_DENIED;
                end else begin
                    had_backlog = (pred_fill != 0) || (pred_lost != 0);
                    if (it.record_length == 0 || it.record_length > EVENT_MAX ||
                        pred_lost != 0 ||
                        int'(it.record_length) + 2 > RING_BYTES - int'(pred_fill)) begin
                        bump_lost();
                        exp.status = ST_DROPPED;
                    end else begin
                        push_ring_byte(it.record_length[7:0]);
                        push_ring_byte(it.record_length[15:8]);
                        pred_body_left = it.record_length;
                    end
                    exp.wake = !had_backlog;
                end
            end
            REQ_PUB_BYTE: begin
                if (pred_body_left == 0) begin
                    exp.status = ST_DENIED;
                end else begin
                    push_ring_byte(it.data_byte);
                    pred_body_left = pred_body_left - 16'd1;
                end
            end
            REQ_RD_HDR: begin
                if (pred_body_left != 0) begin
                    exp.status = ST_EMPTY;
                end else if (pred_open_left != 0) begin
                    exp.status = ST_DENIED;
                end else if (pred_fill >= 2) begin
                    hl = {ring_copy[pred_rd + 10'd1], ring_copy[pred_rd]};
                    if (hl > EVENT_MAX || int'(hl) + 2 > int'(pred_fill)) begin
                        pred_rd = '0;
                        pred_wr = '0;
                        pred_fill = '0;
                        bump_lost();
                        exp.status = ST_CORRUPT;
                    end else if (hl > it.room) begin
                        exp.status = ST_TOO_LARGE;
                        exp.out_length = hl;
                    end else begin
                        pop_ring_bytes(10'd2);
                        pred_open_left = hl;
                        exp.out_length = hl;
                    end
                end else if (pred_fill == 0 && pred_lost != 0) begin
                    exp.status = ST_LOST;
                    lost_snap = pred_lost;
                    reported = 1'b1;
                    pred_lost = '0;
                end else begin
                    exp.status = ST_EMPTY;
                end
            end
            default: begin
                if (pred_open_left == 0 || pred_fill == 0) begin
                    exp.status = ST_DENIED;
                end else begin
                    exp.out_byte = ring_copy[pred_rd];
                    pop_ring_bytes(10'd1);
                    pred_open_left = pred_open_left - 16'd1;
                end
            end
        endcase
        exp.lost_count = reported ? lost_snap : pred_lost;
        exp.ready_res = (pred_fill != 0) || (pred_lost != 0);
        if (exp.status != ST_DENIED) served_count++;
        expected_replies.push_back(exp);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < 20)
            $display("MISMATCH beat %0d %s: got %0h want %0h", out_beats, what, got, want);
        mismatches++;
    endtask

    // Driver: offers the oldest pending request, holds it while stalled.
    always @(posedge i_clk) begin : request_driver
        bit took;
        if (i_rst_n) begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                apply_ring_request(pending_requests.pop_front());
                in_beats++;
                if (in_beats % 64 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
            end
            if (i_in_valid && !took) begin
                // Stalled beat stays on the bus unchanged.
            end else if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_data <= pending_requests[0];
                send_gap = gap_len(sender_quiet);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat and drives the receiver stall.
    always @(posedge i_clk) begin : reply_monitor
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(o_out_data.status), 64'd0);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 64'(o_out_data.status),
                                        64'(want.status));
                    if (o_out_data.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 64'(o_out_data.out_byte),
                                        64'(want.out_byte));
                    if (o_out_data.out_length !== want.out_length)
                        report_mismatch("out_length", 64'(o_out_data.out_length),
                                        64'(want.out_length));
                    if (o_out_data.lost_count !== want.lost_count)
                        report_mismatch("lost_count", o_out_data.lost_count, want.lost_count);
                    if (o_out_data.wake !== want.wake)
                        report_mismatch("wake", 64'(o_out_data.wake), 64'(want.wake));
                    if (o_out_data.ready_res !== want.ready_res)
                        report_mismatch("ready_res", 64'(o_out_data.ready_res),
                                        64'(want.ready_res));
                end
                out_beats++;
                if (out_beats % 64 == 0) receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && out_beats >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = gap_len(receiver_quiet);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_item rand_item();
        t_in_item it;
        it.req_type      = 2'($urandom_range(0, 3));
        it.event_uid     = $urandom;
        it.is_system     = 1'($urandom_range(0, 1));
        it.record_length = 16'($urandom_range(0, 65535));
        it.data_byte     = 8'($urandom_range(0, 255));
        it.room          = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic t_in_item mk(logic [1:0] req, logic [31:0] uid, logic sys,
                                    logic [15:0] len, logic [7:0] data, logic [15:0] room);
        t_in_item it;
        it.req_type      = req;
        it.event_uid     = uid;
        it.is_system     = sys;
        it.record_length = len;
        it.data_byte     = data;
        it.room          = room;
        return it;
    endfunction

    function automatic logic [15:0] pick_length();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) return 16'($urandom_range(1, 24));
        if (k < 80) return 16'($urandom_range(25, EVENT_MAX));
        if (k < 85) return 16'(EVENT_MAX);
        if (k < 90) return 16'($urandom_range(EVENT_MAX + 1, EVENT_MAX + 8));
        if (k < 95) return 16'd0;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] pick_room();
        int k;
        k = $urandom_range(0, 99);
        if (k < 75) return 16'($urandom_range(EVENT_MAX, 65535));
        if (k < 85) return 16'd0;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk); while (pending_requests.size() != 0);
    endtask

    task automatic write_owner(logic [31:0] v);
        wait_drained();
        while (expected_replies.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        pred_owner = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(int target, int pub_weight);
        int       start_cnt;
        int       n;
        int       k;
        t_in_item it;
        start_cnt = served_count;
        while (served_count - start_cnt < target) begin
            wait_drained();
            if (pred_body_left != 0 || pred_open_left != 0) begin
                n = (pred_body_left != 0) ? int'(pred_body_left) : int'(pred_open_left);
                if ($urandom_range(0, 9) == 0) n = $urandom_range(0, n);
                repeat (n) begin
                    it = rand_item();
                    it.req_type = (pred_body_left != 0) ? REQ_PUB_BYTE : REQ_RD_BYTE;
                    pending_requests.push_back(it);
                end
                if ($urandom_range(0, 4) == 0) pending_requests.push_back(rand_item());
            end else begin
                k = $urandom_range(0, 99);
                it = rand_item();
                if (k < 8) begin
                    // Unstructured beat.
                end else if (k < 8 + pub_weight) begin
                    it.req_type = REQ_PUB_START;
                    if ($urandom_range(0, 4) != 0) it.event_uid = pred_owner;
                    if (pred_owner != 0 && $urandom_range(0, 6) != 0) it.is_system = 1'b0;
                    it.record_length = pick_length();
                end else begin
                    it.req_type = REQ_RD_HDR;
                    it.room = pick_room();
                end
                pending_requests.push_back(it);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_owner(32'd0);

        pending_requests.push_back(mk(REQ_RD_HDR, 32'd0, 1'b0, 16'd0, 8'd0, 16'hFFFF));
        pending_requests.push_back(mk(REQ_RD_BYTE, 32'd0, 1'b0, 16'd0, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_BYTE, 32'd0, 1'b0, 16'd0, 8'hFF, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_START, 32'd0, 1'b0, 16'd0, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_RD_HDR, 32'd0, 1'b0, 16'd0, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_START, 32'd7, 1'b0, 16'(EVENT_MAX + 1), 8'd0,
                                      16'd0));
        pending_requests.push_back(mk(REQ_PUB_START, 32'd7, 1'b0, 16'hFFFF, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_RD_HDR, 32'd0, 1'b0, 16'd0, 8'd0, 16'hFFFF));
        pending_requests.push_back(mk(REQ_PUB_START, 32'hFFFF_FFFF, 1'b1, 16'd3, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_RD_HDR, 32'd0, 1'b0, 16'd0, 8'd0, 16'hFFFF));
        pending_requests.push_back(mk(REQ_PUB_START, 32'd0, 1'b0, 16'd5, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_BYTE, 32'd0, 1'b0, 16'd0, 8'h00, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_BYTE, 32'd0, 1'b0, 16'd0, 8'hFF, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_BYTE, 32'd0, 1'b0, 16'd0, 8'h5A, 16'd0));
        pending_requests.push_back(mk(REQ_RD_HDR, 32'd0, 1'b0, 16'd0, 8'd0, 16'd2));
        pending_requests.push_back(mk(REQ_RD_HDR, 32'd0, 1'b0, 16'd0, 8'd0, 16'hFFFF));
        pending_requests.push_back(mk(REQ_RD_HDR, 32'd0, 1'b0, 16'd0, 8'd0, 16'hFFFF));
        repeat (4) pending_requests.push_back(mk(REQ_RD_BYTE, 32'd0, 1'b0, 16'd0, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_START, 32'd0, 1'b0, 16'(EVENT_MAX), 8'd0,
                                      16'd0));
        run_random(250, 60);

        write_owner(32'hFFFF_FFFF);
        pending_requests.push_back(mk(REQ_PUB_START, 32'd0, 1'b0, 16'd4, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_START, 32'hFFFF_FFFF, 1'b1, 16'd4, 8'd0, 16'd0));
        pending_requests.push_back(mk(REQ_PUB_START, 32'hFFFF_FFFF, 1'b0, 16'd1, 8'd0, 16'd0));
        run_random(250, 80);

        write_owner($urandom);
        run_random(250, 45);

        write_owner(32'd0);
        run_random(250, 75);

        wait_drained();
        while (expected_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
